// ----- rtl/core/stodc_pkg.sv -----
package stodc_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  localparam logic [1:0] STAGE_RUN     = 2'd0;
  localparam logic [1:0] STAGE_HOURS   = 2'd1;
  localparam logic [1:0] STAGE_MINUTES = 2'd2;
  localparam logic [1:0] STAGE_SECONDS = 2'd3;

  localparam logic [7:0] BLINK_PERIOD_RESET = 8'd5;
  localparam logic [4:0] LAST_HOUR          = 5'd23;
  localparam logic [5:0] LAST_MINUTE        = 6'd59;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] switch_pins;
  } item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] set_stage;
    logic       refresh;
    logic [5:0] shown_value;
  } result_t;

  // Reduce an 8-bit value modulo 24 by conditional subtraction.
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r[4:0];
  endfunction

  // Reduce an 8-bit value modulo 60 by conditional subtraction.
  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r[5:0];
  endfunction

endpackage

// ----- rtl/core/stodc_chan_if.sv -----
interface stodc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/settable_time_of_day_clock.sv -----
// Timing: an item passes the input register, then the result register, where it is
// offered; the clock state updates in the same cycle the result is formed.
// Throughput: 1 item per cycle while results are taken; the wrap, divider and modulo
// logic all sit in one stage.
// Reset (rst, synchronous, active high): time 00:00:00, running stage, blink count
// and last switch value zero, blink period 5, both registers empty.
module settable_time_of_day_clock (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  stodc_chan_if.sink          items,
  stodc_chan_if.source        results
);
  import stodc_pkg::*;

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_result;
  logic       advance;

  logic [7:0] blink_period;
  logic [4:0] hour_count;
  logic [5:0] minute_count;
  logic [5:0] second_count;
  logic [1:0] stage;
  logic [7:0] blink_count;
  logic [7:0] last_switch_value;

  logic [4:0] hour_count_next;
  logic [5:0] minute_count_next;
  logic [5:0] second_count_next;
  logic [1:0] stage_next;
  logic [7:0] blink_count_next;
  logic [7:0] last_switch_value_next;
  logic       refresh_next;
  logic [5:0] shown_next;
  logic [7:0] blink_inc;
  logic [7:0] switch_value;

  // Move the held item into the result register when that register is free or draining.
  assign advance     = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || advance;

  assign results.valid   = out_valid;
  assign results.payload = out_result;

  assign blink_inc    = blink_count + 8'd1;
  assign switch_value = ~in_item.switch_pins;

  always_comb begin
    hour_count_next        = hour_count;
    minute_count_next      = minute_count;
    second_count_next      = second_count;
    stage_next             = stage;
    blink_count_next       = blink_count;
    last_switch_value_next = last_switch_value;
    refresh_next           = 1'b0;
    unique case (in_item.opcode)
      OP_TICK: begin
        if (stage == STAGE_RUN) begin
          refresh_next = 1'b1;
          if (second_count == LAST_MINUTE) begin
            second_count_next = '0;
            if (minute_count == LAST_MINUTE) begin
              minute_count_next = '0;
              hour_count_next   = (hour_count == LAST_HOUR) ? '0 : hour_count + 5'd1;
            end else begin
              minute_count_next = minute_count + 6'd1;
            end
          end else begin
            second_count_next = second_count + 6'd1;
          end
        end else if (blink_inc >= blink_period) begin
          blink_count_next = '0;
          refresh_next     = 1'b1;
        end else begin
          blink_count_next = blink_inc;
        end
      end
      OP_BUTTON: begin
        stage_next = stage + 2'd1;
      end
      OP_SWITCH: begin
        // Take a new switch value only while a field is being set.
        if (stage != STAGE_RUN && switch_value != last_switch_value) begin
          last_switch_value_next = switch_value;
          refresh_next           = 1'b1;
          case (stage)
            STAGE_HOURS:   hour_count_next   = mod24(switch_value);
            STAGE_MINUTES: minute_count_next = mod60(switch_value);
            default:       second_count_next = mod60(switch_value);
          endcase
        end
      end
      default: ;
    endcase

    case (stage_next)
      STAGE_HOURS:   shown_next = {1'b0, hour_count_next};
      STAGE_MINUTES: shown_next = minute_count_next;
      STAGE_SECONDS: shown_next = second_count_next;
      default:       shown_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      blink_period      <= BLINK_PERIOD_RESET;
      hour_count        <= '0;
      minute_count      <= '0;
      second_count      <= '0;
      stage             <= STAGE_RUN;
      blink_count       <= '0;
      last_switch_value <= '0;
    end else begin
      if (cfg_we) begin
        blink_period <= cfg_wdata;
      end
      if (items.ready) begin
        in_valid <= items.valid;
      end
      if (advance) begin
        out_valid         <= 1'b1;
        hour_count        <= hour_count_next;
        minute_count      <= minute_count_next;
        second_count      <= second_count_next;
        stage             <= stage_next;
        blink_count       <= blink_count_next;
        last_switch_value <= last_switch_value_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a transfer loads them.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item <= items.payload;
    end
    if (advance) begin
      out_result.hours       <= hour_count_next;
      out_result.minutes     <= minute_count_next;
      out_result.seconds     <= second_count_next;
      out_result.set_stage   <= stage_next;
      out_result.refresh     <= refresh_next;
      out_result.shown_value <= shown_next;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import stodc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 310;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  item_t in_item = '0;
  logic out_ready = 1'b0;

  stodc_chan_if #(.payload_t(item_t)) item_ch ();
  stodc_chan_if #(.payload_t(result_t)) result_ch ();

  assign item_ch.valid = in_valid;
  assign item_ch.payload = in_item;
  assign result_ch.ready = out_ready;

  settable_time_of_day_clock u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .items(item_ch),
    .results(result_ch)
  );

  always #5 clk = ~clk;

  // Clock state as the block should hold it
  logic [4:0] hour_now = '0;
  logic [5:0] minute_now = '0;
  logic [5:0] second_now = '0;
  logic [1:0] stage_now = STAGE_RUN;
  logic [7:0] blink_ticks = '0;
  logic [7:0] switch_taken = '0;
  logic [7:0] blink_limit = BLINK_PERIOD_RESET;

  item_t pending_items[$];
  result_t expected_displays[$];
  int gap_pct = 17;
  int stall_pct = 73;
  int mismatch_count = 0;
  int gen_count = 0;
  logic [1:0] gen_stage = STAGE_RUN;

  function automatic result_t display_after(item_t it);
    result_t r;
    logic [7:0] level;
    r = '0;
    level = ~it.switch_pins;
    case (it.opcode)
      OP_TICK: begin
        if (stage_now == STAGE_RUN) begin
          r.refresh = 1'b1;
          if (second_now != LAST_MINUTE) begin
            second_now = second_now + 6'd1;
          end else begin
            second_now = '0;
            if (minute_now != LAST_MINUTE) begin
              minute_now = minute_now + 6'd1;
            end else begin
              minute_now = '0;
              hour_now = (hour_now == LAST_HOUR) ? 5'd0 : hour_now + 5'd1;
            end
          end
        end else begin
          blink_ticks = blink_ticks + 8'd1;
          if (blink_ticks >= blink_limit) begin
            blink_ticks = '0;
            r.refresh = 1'b1;
          end
        end
      end
      OP_BUTTON: begin
        stage_now = (stage_now == STAGE_SECONDS) ? STAGE_RUN : stage_now + 2'd1;
      end
      OP_SWITCH: begin
        // pins are active low; only a new value in a set stage is taken
        if (stage_now != STAGE_RUN && level != switch_taken) begin
          switch_taken = level;
          r.refresh = 1'b1;
          case (stage_now)
            STAGE_HOURS: hour_now = 5'(level % 8'd24);
            STAGE_MINUTES: minute_now = 6'(level % 8'd60);
            default: second_now = 6'(level % 8'd60);
          endcase
        end
      end
      default: ;
    endcase
    r.hours = hour_now;
    r.minutes = minute_now;
    r.seconds = second_now;
    r.set_stage = stage_now;
    case (stage_now)
      STAGE_HOURS: r.shown_value = 6'(hour_now);
      STAGE_MINUTES: r.shown_value = minute_now;
      STAGE_SECONDS: r.shown_value = second_now;
      default: r.shown_value = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Sender: hold the item until its transfer, then advance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && item_ch.ready)
        expected_displays.push_back(display_after(in_item));
      if (!in_valid || item_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_ch.valid && out_ready) begin
        if (expected_displays.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %p", result_ch.payload);
        end else begin
          want = expected_displays.pop_front();
          check_field("hours", want.hours, result_ch.payload.hours);
          check_field("minutes", want.minutes, result_ch.payload.minutes);
          check_field("seconds", want.seconds, result_ch.payload.seconds);
          check_field("set_stage", want.set_stage, result_ch.payload.set_stage);
          check_field("refresh", want.refresh, result_ch.payload.refresh);
          check_field("shown_value", want.shown_value, result_ch.payload.shown_value);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_item(logic [1:0] op, logic [7:0] pins);
    item_t it;
    it.opcode = op;
    it.switch_pins = pins;
    pending_items.push_back(it);
    gen_count++;
    if (op == OP_BUTTON)
      gen_stage = (gen_stage == STAGE_SECONDS) ? STAGE_RUN : gen_stage + 2'd1;
  endtask

  // Pins whose inverted level reduces to target
  function automatic logic [7:0] pins_for(int unsigned target, int unsigned modulus);
    int unsigned k;
    k = $urandom_range((255 - target) / modulus);
    return ~8'(target + modulus * k);
  endfunction

  task automatic add_random_items(int count);
    int goal;
    int kind;
    int unsigned last;
    int unsigned modulus;
    logic [7:0] pins;
    goal = gen_count + count;
    while (gen_count < goal) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        // full set pass: hours, minutes, seconds, then a run of ticks
        while (gen_stage != STAGE_HOURS)
          queue_item(OP_BUTTON, 8'($urandom));
        repeat (3) begin
          last = (gen_stage == STAGE_HOURS) ? 23 : 59;
          modulus = (gen_stage == STAGE_HOURS) ? 24 : 60;
          repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(3))
              0: pins = 8'($urandom);
              1: pins = pins_for(0, modulus);
              default: pins = pins_for(last - $urandom_range(2), modulus);
            endcase
            queue_item(OP_SWITCH, pins);
            if ($urandom_range(3) == 0)
              queue_item(OP_SWITCH, pins);
            repeat ($urandom_range(2))
              queue_item(OP_TICK, 8'($urandom));
          end
          queue_item(OP_BUTTON, 8'($urandom));
        end
        repeat ($urandom_range(40, 1))
          queue_item(OP_TICK, 8'($urandom));
      end else if (kind < 8) begin
        if (kind == 7)
          queue_item(OP_BUTTON, 8'($urandom));
        repeat ($urandom_range(30, 1))
          queue_item(OP_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(6, 1))
          queue_item(2'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  // Sample after the edge so the sender's and monitor's updates have settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_displays.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_blink(logic [7:0] period);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
    blink_limit = period;
  endtask

  initial begin
    logic [7:0] blink_plan [6];
    blink_plan = '{8'd255, 8'd1, 8'd7, 8'd0, 8'd3, 8'd128};
    blink_plan[3] = 8'($urandom_range(255, 1));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_item(OP_TICK, 8'h00);
    queue_item(OP_SWITCH, 8'h00);
    queue_item(OP_UNUSED, 8'hFF);
    queue_item(OP_BUTTON, 8'h00);
    queue_item(OP_SWITCH, 8'h00);
    queue_item(OP_SWITCH, 8'h00);
    queue_item(OP_SWITCH, ~8'd23);
    queue_item(OP_BUTTON, 8'hFF);
    queue_item(OP_SWITCH, ~8'd59);
    queue_item(OP_BUTTON, 8'h00);
    queue_item(OP_SWITCH, ~8'd179);
    repeat (5) queue_item(OP_TICK, 8'h00);
    queue_item(OP_SWITCH, 8'hFF);
    queue_item(OP_SWITCH, ~8'd59);
    queue_item(OP_BUTTON, 8'h00);
    queue_item(OP_TICK, 8'h00);
    // leave the divider part way, then drop the period below its count
    queue_item(OP_BUTTON, 8'h00);
    repeat (4) queue_item(OP_TICK, 8'h00);
    set_blink(8'd2);
    queue_item(OP_TICK, 8'h00);
    set_blink(8'd0);
    repeat (2) queue_item(OP_TICK, 8'h00);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        gap_pct = 73;
        stall_pct = 17;
      end
      if (p == 4) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      set_blink(blink_plan[p]);
      add_random_items(ITEMS_PER_PHASE);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("[settable_time_of_day_clock] OK");
    else
      $display("[settable_time_of_day_clock] ERROR");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[settable_time_of_day_clock] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/stodc_pkg.sv
rtl/core/stodc_chan_if.sv
rtl/core/settable_time_of_day_clock.sv
tb/sv/tb_top.sv
